// ===== design/gzbpc_pkg.sv =====
// Package for the grid zone bright pixel counter: constants, register codes, shared types.
`timescale 1ns / 1ps
`default_nettype none

package gzbpc_pkg;

  // Default geometry
  localparam int unsigned GRID_SIDE_DEF  = 4;
  localparam int unsigned COORD_BITS_DEF = 11;

  // Fixed field widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned SIZE_W    = 8;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned LABEL_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // Reset values of the configuration registers
  localparam logic [SIZE_W-1:0]  CELL_SIZE_RST  = 8'd50;
  localparam logic [PIX_W-1:0]   PIX_THR_RST    = 8'd240;
  localparam logic [CNT_W-1:0]   CNT_THR_RST    = 16'd100;
  localparam logic [LABEL_W-1:0] COLOR_RST      = 2'd0;

  // Label meaning "no color assigned yet"
  localparam logic [LABEL_W-1:0] LABEL_UNASSIGNED = 2'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_CELL_SIZE    = 3'd2,
    CFG_PIX_THR      = 3'd3,
    CFG_CNT_THR      = 3'd4,
    CFG_COLOR_LABEL  = 3'd5
  } cfg_reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DRAIN  = 3'b010,
    ST_REPORT = 3'b100
  } state_e;

  // Controller to datapath command
  typedef struct packed {
    logic load;   // emit the selected cell into the output register and clear it
    logic last;   // selected cell is the final one of the report
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== design/grid_zone_bright_pixel_counter_core.sv =====
// Top level of the grid zone bright pixel counter: controller plus datapath.
// Pixels: one item per cycle while no report runs; a count is written after the stage A registers.
// End of frame: intake stalls; the controller steps through ST_DRAIN into ST_REPORT, and the
// GRID_SIDE*GRID_SIDE results follow one per cycle from the report counter, slowed
// only by output stall. Intake resumes the cycle after the last result is loaded.
// Reset: counts zero, labels unassigned, configuration registers at their defaults.
`timescale 1ns / 1ps
`default_nettype none

module grid_zone_bright_pixel_counter_core #(
  parameter int unsigned GRID_SIDE  = gzbpc_pkg::GRID_SIDE_DEF,
  parameter int unsigned COORD_BITS = gzbpc_pkg::COORD_BITS_DEF,
  localparam int unsigned Cells     = GRID_SIDE * GRID_SIDE,
  localparam int unsigned IdxW      = $clog2(Cells),
  localparam int unsigned CfgW      = (COORD_BITS > gzbpc_pkg::CNT_W) ?
                                      COORD_BITS : gzbpc_pkg::CNT_W
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [gzbpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CfgW-1:0]                   cfg_wdata_i,
  // pixel channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [COORD_BITS-1:0]             pixel_x_i,
  input  wire logic [COORD_BITS-1:0]             pixel_y_i,
  input  wire logic [gzbpc_pkg::PIX_W-1:0]       pixel_value_i,
  input  wire logic                              end_of_frame_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [IdxW-1:0]                        cell_index_o,
  output logic [gzbpc_pkg::CNT_W-1:0]            bright_count_o,
  output logic [gzbpc_pkg::LABEL_W-1:0]          cell_label_o,
  output logic                                   last_cell_o
);

  logic                 in_accept;
  logic                 out_free;
  gzbpc_pkg::ctrl_cmd_t cmd;
  logic [IdxW-1:0]      rep_idx;

  gzbpc_ctrl #(
    .GRID_SIDE (GRID_SIDE)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .end_of_frame_i (end_of_frame_i),
    .in_stall_o     (in_stall_o),
    .in_accept_o    (in_accept),
    .out_free_i     (out_free),
    .cmd_o          (cmd),
    .rep_idx_o      (rep_idx)
  );

  gzbpc_datapath #(
    .GRID_SIDE  (GRID_SIDE),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_accept_i    (in_accept),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .pixel_value_i  (pixel_value_i),
    .cmd_i          (cmd),
    .rep_idx_i      (rep_idx),
    .out_free_o     (out_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cell_index_o   (cell_index_o),
    .bright_count_o (bright_count_o),
    .cell_label_o   (cell_label_o),
    .last_cell_o    (last_cell_o)
  );

endmodule

`default_nettype wire

// ===== design/gzbpc_ctrl.sv =====
// Controller of the grid zone bright pixel counter: pixel intake and cell report sequencing.
`timescale 1ns / 1ps
`default_nettype none

module gzbpc_ctrl #(
  parameter int unsigned GRID_SIDE = gzbpc_pkg::GRID_SIDE_DEF,
  localparam int unsigned Cells    = GRID_SIDE * GRID_SIDE,
  localparam int unsigned IdxW     = $clog2(Cells)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  end_of_frame_i,
  output logic                       in_stall_o,
  output logic                       in_accept_o,
  input  wire logic                  out_free_i,
  output gzbpc_pkg::ctrl_cmd_t       cmd_o,
  output logic [IdxW-1:0]            rep_idx_o
);

  gzbpc_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              is_last;

  // Intake only while idle
  assign in_stall_o  = (state_q != gzbpc_pkg::ST_IDLE);
  assign in_accept_o = in_valid_i && !in_stall_o;

  assign is_last   = (idx_q == IdxW'(Cells - 1));
  assign rep_idx_o = idx_q;

  // Next state and report counter
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o.load = 1'b0;
    cmd_o.last = is_last;
    case (state_q)
      gzbpc_pkg::ST_IDLE: begin
        if (in_accept_o && end_of_frame_i) begin
          state_d = gzbpc_pkg::ST_DRAIN;
        end
      end
      // final pixel's count update lands here
      gzbpc_pkg::ST_DRAIN: begin
        state_d = gzbpc_pkg::ST_REPORT;
        idx_d   = '0;
      end
      gzbpc_pkg::ST_REPORT: begin
        if (out_free_i) begin
          cmd_o.load = 1'b1;
          idx_d      = idx_q + IdxW'(1);
          if (is_last) begin
            state_d = gzbpc_pkg::ST_IDLE;
            idx_d   = '0;
          end
        end
      end
      default: begin
        state_d = gzbpc_pkg::ST_IDLE;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gzbpc_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/gzbpc_datapath.sv =====
// Datapath of the grid zone bright pixel counter: config registers, cell lookup, counts, output.
`timescale 1ns / 1ps
`default_nettype none

module gzbpc_datapath #(
  parameter int unsigned GRID_SIDE  = gzbpc_pkg::GRID_SIDE_DEF,
  parameter int unsigned COORD_BITS = gzbpc_pkg::COORD_BITS_DEF,
  localparam int unsigned Cells     = GRID_SIDE * GRID_SIDE,
  localparam int unsigned IdxW      = $clog2(Cells),
  localparam int unsigned CfgW      = (COORD_BITS > gzbpc_pkg::CNT_W) ?
                                      COORD_BITS : gzbpc_pkg::CNT_W
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [gzbpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CfgW-1:0]                   cfg_wdata_i,
  // pixel intake
  input  wire logic                              in_accept_i,
  input  wire logic [COORD_BITS-1:0]             pixel_x_i,
  input  wire logic [COORD_BITS-1:0]             pixel_y_i,
  input  wire logic [gzbpc_pkg::PIX_W-1:0]       pixel_value_i,
  // controller
  input  gzbpc_pkg::ctrl_cmd_t                   cmd_i,
  input  wire logic [IdxW-1:0]                   rep_idx_i,
  output logic                                   out_free_o,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [IdxW-1:0]                        cell_index_o,
  output logic [gzbpc_pkg::CNT_W-1:0]            bright_count_o,
  output logic [gzbpc_pkg::LABEL_W-1:0]          cell_label_o,
  output logic                                   last_cell_o
);

  localparam int unsigned SideW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  // width holding GRID_SIDE * cell_size; CmpW also holds a coordinate offset
  localparam int unsigned BndW  = gzbpc_pkg::SIZE_W + $clog2(GRID_SIDE + 1);
  localparam int unsigned CmpW  = (COORD_BITS > BndW) ? COORD_BITS : BndW;

  // configuration registers
  logic [COORD_BITS-1:0]              origin_x_q, origin_y_q;
  logic [gzbpc_pkg::SIZE_W-1:0]       cell_size_q;
  logic [gzbpc_pkg::PIX_W-1:0]        pix_thr_q;
  logic [gzbpc_pkg::CNT_W-1:0]        cnt_thr_q;
  logic [gzbpc_pkg::LABEL_W-1:0]      color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      cell_size_q <= gzbpc_pkg::CELL_SIZE_RST;
      pix_thr_q   <= gzbpc_pkg::PIX_THR_RST;
      cnt_thr_q   <= gzbpc_pkg::CNT_THR_RST;
      color_q     <= gzbpc_pkg::COLOR_RST;
    end else if (cfg_we_i) begin
      case (gzbpc_pkg::cfg_reg_e'(cfg_idx_i))
        gzbpc_pkg::CFG_ORIGIN_X:    origin_x_q  <= cfg_wdata_i[COORD_BITS-1:0];
        gzbpc_pkg::CFG_ORIGIN_Y:    origin_y_q  <= cfg_wdata_i[COORD_BITS-1:0];
        gzbpc_pkg::CFG_CELL_SIZE:   cell_size_q <= cfg_wdata_i[gzbpc_pkg::SIZE_W-1:0];
        gzbpc_pkg::CFG_PIX_THR:     pix_thr_q   <= cfg_wdata_i[gzbpc_pkg::PIX_W-1:0];
        gzbpc_pkg::CFG_CNT_THR:     cnt_thr_q   <= cfg_wdata_i[gzbpc_pkg::CNT_W-1:0];
        gzbpc_pkg::CFG_COLOR_LABEL: color_q     <= cfg_wdata_i[gzbpc_pkg::LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage A: offsets from the origin and the bright / upper-left / nonzero cell size test
  logic                  a_hit_d, a_hit_q;
  logic [COORD_BITS-1:0] a_dx_q, a_dy_q;

  assign a_hit_d = in_accept_i && (pixel_value_i > pix_thr_q) &&
                   (pixel_x_i >= origin_x_q) && (pixel_y_i >= origin_y_q) &&
                   (cell_size_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_hit_q <= 1'b0;
    end else begin
      a_hit_q <= a_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      a_dx_q <= pixel_x_i - origin_x_q;
      a_dy_q <= pixel_y_i - origin_y_q;
    end
  end

  // Stage B: column and row by comparing against multiples of the cell size
  logic [CmpW-1:0]  dx_ext, dy_ext, grid_span;
  logic [SideW-1:0] col_b, row_b;
  logic             in_grid;
  logic [IdxW-1:0]  cell_b;

  assign dx_ext    = CmpW'(a_dx_q);
  assign dy_ext    = CmpW'(a_dy_q);
  assign grid_span = CmpW'(GRID_SIDE) * CmpW'(cell_size_q);
  assign in_grid   = (dx_ext < grid_span) && (dy_ext < grid_span);

  always_comb begin
    col_b = '0;
    row_b = '0;
    for (int k = 1; k < GRID_SIDE; k++) begin
      if (dx_ext >= CmpW'(k) * CmpW'(cell_size_q)) col_b = col_b + SideW'(1);
      if (dy_ext >= CmpW'(k) * CmpW'(cell_size_q)) row_b = row_b + SideW'(1);
    end
  end

  assign cell_b = IdxW'(row_b) * IdxW'(GRID_SIDE) + IdxW'(col_b);

  // Cell counts and labels; counts have one read address shared by report and update
  logic [gzbpc_pkg::CNT_W-1:0]   counts_q [Cells];
  logic [gzbpc_pkg::LABEL_W-1:0] labels_q [Cells];
  logic [IdxW-1:0]               rd_idx;
  logic [gzbpc_pkg::CNT_W-1:0]   cnt_rd, cnt_inc;
  logic [gzbpc_pkg::LABEL_W-1:0] lbl_new;
  logic                          cnt_upd;

  assign rd_idx  = cmd_i.load ? rep_idx_i : cell_b;
  assign cnt_rd  = counts_q[rd_idx];
  assign cnt_inc = cnt_rd + gzbpc_pkg::CNT_W'(1);
  assign cnt_upd = a_hit_q && in_grid && (cnt_rd != '1);

  // marked cells take the configured color unless it is the unassigned code
  assign lbl_new = ((cnt_rd > cnt_thr_q) && (color_q != gzbpc_pkg::LABEL_UNASSIGNED)) ?
                   color_q : labels_q[rep_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Cells; i++) begin
        counts_q[i] <= '0;
        labels_q[i] <= gzbpc_pkg::LABEL_UNASSIGNED;
      end
    end else if (cmd_i.load) begin
      counts_q[rep_idx_i] <= '0;
      labels_q[rep_idx_i] <= lbl_new;
    end else if (cnt_upd) begin
      counts_q[cell_b] <= cnt_inc;
    end
  end

  // Output register
  logic out_valid_q;

  assign out_free_o  = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cell_index_o   <= rep_idx_i;
      bright_count_o <= cnt_rd;
      cell_label_o   <= lbl_new;
      last_cell_o    <= cmd_i.last;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/grid_zone_bright_pixel_counter_core_tb.sv =====
// Self-checking testbench for the grid zone bright pixel counter core.
`timescale 1ns / 1ps

module grid_zone_bright_pixel_counter_core_tb;

  localparam int unsigned GRID         = gzbpc_pkg::GRID_SIDE_DEF;
  localparam int unsigned CELLS        = GRID * GRID;
  localparam int unsigned XY_W         = gzbpc_pkg::COORD_BITS_DEF;
  localparam int unsigned XY_MAX       = (1 << XY_W) - 1;
  localparam int unsigned CNT_W        = gzbpc_pkg::CNT_W;
  localparam int unsigned PIX_W        = gzbpc_pkg::PIX_W;
  localparam int unsigned SIZE_W       = gzbpc_pkg::SIZE_W;
  localparam int unsigned LABEL_W      = gzbpc_pkg::LABEL_W;
  localparam int unsigned CFG_IDX_W    = gzbpc_pkg::CFG_IDX_W;
  localparam int unsigned CFG_W        = (XY_W > CNT_W) ? XY_W : CNT_W;
  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 48;
  localparam int unsigned MAX_PRINTS   = 60;
  localparam longint      TIMEOUT_NS   = 10_000_000;

  // Register slots past the last real one; writes there must do nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  // Cell labels
  localparam logic [LABEL_W-1:0] LBL_BLUE  = 2'd0;
  localparam logic [LABEL_W-1:0] LBL_GREEN = 2'd1;
  localparam logic [LABEL_W-1:0] LBL_RED   = 2'd2;

  typedef struct packed {
    logic [3:0]         idx;
    logic [CNT_W-1:0]   count;
    logic [LABEL_W-1:0] label;
    logic               last;
  } cell_report_t;

  // One row of the directed table: a register write or a pixel
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     wdata;
    logic [XY_W-1:0]      px;
    logic [XY_W-1:0]      py;
    logic [PIX_W-1:0]     pv;
    logic                 eof;
    logic                 typed;
    logic [3:0]           t_cell;
    logic [CNT_W-1:0]     t_count;
    logic [LABEL_W-1:0]   t_label;
  } dir_row_t;

  // DUT signals
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i      = '0;
  logic [CFG_W-1:0]     cfg_wdata_i    = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [XY_W-1:0]      pixel_x_i      = '0;
  logic [XY_W-1:0]      pixel_y_i      = '0;
  logic [PIX_W-1:0]     pixel_value_i  = '0;
  logic                 end_of_frame_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [3:0]           cell_index_o;
  logic [CNT_W-1:0]     bright_count_o;
  logic [LABEL_W-1:0]   cell_label_o;
  logic                 last_cell_o;

  // Shadow of the configuration registers
  logic [XY_W-1:0]    org_x;
  logic [XY_W-1:0]    org_y;
  logic [SIZE_W-1:0]  csize;
  logic [PIX_W-1:0]   pix_thr;
  logic [CNT_W-1:0]   cnt_thr;
  logic [LABEL_W-1:0] color;

  // Predicted per-cell state
  logic [CNT_W-1:0]   cell_tally [CELLS];
  logic [LABEL_W-1:0] cell_tag   [CELLS];

  cell_report_t cell_reports_due [$];
  dir_row_t     dir_tab [$];

  // Hand-typed expectation for one cell of the next report
  logic               typed_on = 1'b0;
  logic [3:0]         typed_cell;
  logic [CNT_W-1:0]   typed_count;
  logic [LABEL_W-1:0] typed_label;

  logic        idle_en  = 1'b1;
  logic        hold_req = 1'b0;
  int unsigned mismatches = 0;

  grid_zone_bright_pixel_counter_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .pixel_value_i  (pixel_value_i),
    .end_of_frame_i (end_of_frame_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cell_index_o   (cell_index_o),
    .bright_count_o (bright_count_o),
    .cell_label_o   (cell_label_o),
    .last_cell_o    (last_cell_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < MAX_PRINTS) begin
      $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Count one pixel; on end of frame, queue the 16 cell reports and clear
  function automatic void tally_pixel(logic [XY_W-1:0] x, logic [XY_W-1:0] y,
                                      logic [PIX_W-1:0] v, logic eof);
    int unsigned  col;
    int unsigned  row;
    int unsigned  cell_no;
    cell_report_t rep;
    if (v > pix_thr && csize != 0 && x >= org_x && y >= org_y) begin
      col = (x - org_x) / csize;
      row = (y - org_y) / csize;
      if (col < GRID && row < GRID) begin
        cell_no = row * GRID + col;
        if (cell_tally[cell_no] != {CNT_W{1'b1}}) cell_tally[cell_no]++;
      end
    end
    if (eof) begin
      for (int i = 0; i < CELLS; i++) begin
        if (cell_tally[i] > cnt_thr && color != gzbpc_pkg::LABEL_UNASSIGNED) begin
          cell_tag[i] = color;
        end
        rep.idx   = 4'(i);
        rep.count = cell_tally[i];
        rep.label = cell_tag[i];
        rep.last  = (i == CELLS - 1);
        if (typed_on && typed_cell == i) begin
          rep.count = typed_count;
          rep.label = typed_label;
        end
        cell_reports_due.push_back(rep);
        cell_tally[i] = '0;
      end
      typed_on = 1'b0;
    end
  endfunction

  // Fill the unused upper bits of a write with noise
  function automatic logic [CFG_W-1:0] with_junk(logic [CFG_W-1:0] val, int unsigned w);
    logic [CFG_W-1:0] mask;
    mask = (CFG_W'(1) << w) - CFG_W'(1);
    return (CFG_W'($urandom) & ~mask) | (val & mask);
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int unsigned d);
    dir_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.wdata   = CFG_W'(d);
    return r;
  endfunction

  function automatic dir_row_t pix_row(int unsigned x, int unsigned y, int unsigned v);
    dir_row_t r;
    r = '0;
    r.px = XY_W'(x);
    r.py = XY_W'(y);
    r.pv = PIX_W'(v);
    return r;
  endfunction

  // End-of-frame pixel with a hand-typed expectation for one cell
  function automatic dir_row_t eof_row(int unsigned x, int unsigned y, int unsigned v,
                                       int unsigned cell_no, int unsigned cnt,
                                       logic [LABEL_W-1:0] lbl);
    dir_row_t r;
    r = pix_row(x, y, v);
    r.eof     = 1'b1;
    r.typed   = 1'b1;
    r.t_cell  = 4'(cell_no);
    r.t_count = CNT_W'(cnt);
    r.t_label = lbl;
    return r;
  endfunction

  // Called at a falling edge; leaves the write enable high for a following write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    case (idx)
      gzbpc_pkg::CFG_ORIGIN_X:    org_x   = data[XY_W-1:0];
      gzbpc_pkg::CFG_ORIGIN_Y:    org_y   = data[XY_W-1:0];
      gzbpc_pkg::CFG_CELL_SIZE:   csize   = data[SIZE_W-1:0];
      gzbpc_pkg::CFG_PIX_THR:     pix_thr = data[PIX_W-1:0];
      gzbpc_pkg::CFG_CNT_THR:     cnt_thr = data[CNT_W-1:0];
      gzbpc_pkg::CFG_COLOR_LABEL: color   = data[LABEL_W-1:0];
      default: ;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_pixel(logic [XY_W-1:0] x, logic [XY_W-1:0] y,
                            logic [PIX_W-1:0] v, logic eof);
    cfg_we_i <= 1'b0;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pixel_x_i      <= x;
    pixel_y_i      <= y;
    pixel_value_i  <= v;
    end_of_frame_i <= eof;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tally_pixel(x, y, v, eof);
    @(negedge clk_i);
  endtask

  // Drop the input, wait for every report, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    cfg_we_i   <= 1'b0;
    while (cell_reports_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Output stall: random bursts, plus one long hold-off on request
  initial begin : result_pace
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && stall_left == 0) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Compare each accepted result with the oldest pending report
  always @(posedge clk_i) begin : result_check
    cell_report_t due;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (cell_reports_due.size() == 0) begin
        flag_mismatch("unexpected result, cell_index", cell_index_o, 0);
      end else begin
        due = cell_reports_due.pop_front();
        if (cell_index_o !== due.idx)     flag_mismatch("cell_index", cell_index_o, due.idx);
        if (bright_count_o !== due.count) flag_mismatch("bright_count", bright_count_o, due.count);
        if (cell_label_o !== due.label)   flag_mismatch("cell_label", cell_label_o, due.label);
        if (last_cell_o !== due.last)     flag_mismatch("last_cell", last_cell_o, due.last);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [XY_W-1:0]    px;
    logic [XY_W-1:0]    py;
    logic [PIX_W-1:0]   pv;
    logic [XY_W-1:0]    sx;
    logic [XY_W-1:0]    sy;
    logic [SIZE_W-1:0]  ss;
    logic [PIX_W-1:0]   spt;
    logic [CNT_W-1:0]   sct;
    logic [LABEL_W-1:0] scol;
    int unsigned        hx;
    int unsigned        hy;
    int unsigned        flen;
    int unsigned        sent;

    // Reset values of the shadow registers and cell state
    org_x   = '0;
    org_y   = '0;
    csize   = gzbpc_pkg::CELL_SIZE_RST;
    pix_thr = gzbpc_pkg::PIX_THR_RST;
    cnt_thr = gzbpc_pkg::CNT_THR_RST;
    color   = gzbpc_pkg::COLOR_RST;
    for (int i = 0; i < CELLS; i++) begin
      cell_tally[i] = '0;
      cell_tag[i]   = gzbpc_pkg::LABEL_UNASSIGNED;
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    dir_tab = '{
      eof_row(0, 0, 255, 0, 1, gzbpc_pkg::LABEL_UNASSIGNED),   // fresh labels unassigned
      cfg_row(gzbpc_pkg::CFG_CNT_THR, 0),
      eof_row(199, 199, 241, 15, 1, LBL_BLUE),                 // last cell of default grid
      pix_row(200, 0, 255),                                    // just right of grid
      pix_row(XY_MAX, XY_MAX, 255),
      pix_row(0, 0, 240),                                      // equal to threshold
      eof_row(0, 200, 255, 0, 0, gzbpc_pkg::LABEL_UNASSIGNED), // just below grid
      cfg_row(gzbpc_pkg::CFG_ORIGIN_X, 16'hFFFF),              // masked to 11 bits
      cfg_row(gzbpc_pkg::CFG_ORIGIN_Y, XY_MAX),
      cfg_row(gzbpc_pkg::CFG_CELL_SIZE, 255),
      cfg_row(gzbpc_pkg::CFG_COLOR_LABEL, LBL_RED),
      pix_row(XY_MAX, XY_MAX, 255),
      pix_row(XY_MAX - 1, XY_MAX, 255),                        // left of origin
      pix_row(XY_MAX, XY_MAX - 1, 255),                        // above origin
      eof_row(XY_MAX, XY_MAX, 255, 0, 2, LBL_RED),             // grid runs off the edge
      cfg_row(gzbpc_pkg::CFG_CELL_SIZE, 0),
      eof_row(XY_MAX, XY_MAX, 255, 0, 0, LBL_RED),             // empty grid still reports
      cfg_row(CFG_SPARE_A, 16'hFFFF),
      cfg_row(CFG_SPARE_B, 16'h0000),
      cfg_row(gzbpc_pkg::CFG_COLOR_LABEL, 16'hFFFF),           // label three: keep labels
      cfg_row(gzbpc_pkg::CFG_ORIGIN_X, 0),
      cfg_row(gzbpc_pkg::CFG_ORIGIN_Y, 0),
      cfg_row(gzbpc_pkg::CFG_CELL_SIZE, 1),
      cfg_row(gzbpc_pkg::CFG_PIX_THR, 0),
      pix_row(0, 0, 1),
      pix_row(1, 0, 1),
      pix_row(3, 3, 1),
      pix_row(4, 0, 1),
      pix_row(0, 0, 0),
      eof_row(0, 0, 255, 0, 2, LBL_RED),
      cfg_row(gzbpc_pkg::CFG_PIX_THR, 255),                    // nothing can be bright
      cfg_row(gzbpc_pkg::CFG_CNT_THR, 16'hFFFF),
      cfg_row(gzbpc_pkg::CFG_COLOR_LABEL, LBL_GREEN),
      eof_row(0, 0, 255, 0, 0, LBL_RED),
      cfg_row(gzbpc_pkg::CFG_PIX_THR, 254),
      cfg_row(gzbpc_pkg::CFG_CNT_THR, 0),
      cfg_row(gzbpc_pkg::CFG_CELL_SIZE, 255),
      eof_row(1019, 1019, 255, 15, 1, LBL_GREEN)               // far corner of widest grid
    };
    foreach (dir_tab[r]) begin
      if (dir_tab[r].is_cfg) begin
        settle();
        write_reg(dir_tab[r].reg_idx, dir_tab[r].wdata);
      end else begin
        typed_on    = dir_tab[r].typed;
        typed_cell  = dir_tab[r].t_cell;
        typed_count = dir_tab[r].t_count;
        typed_label = dir_tab[r].t_label;
        send_pixel(dir_tab[r].px, dir_tab[r].py, dir_tab[r].pv, dir_tab[r].eof);
      end
    end

    // Random phases, each under its own setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      sx   = XY_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, XY_MAX)
                                               : $urandom_range(0, 200));
      sy   = XY_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, XY_MAX)
                                               : $urandom_range(0, 200));
      ss   = SIZE_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(1, 24));
      spt  = PIX_W'($urandom_range(0, 255));
      sct  = CNT_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 6));
      scol = LABEL_W'($urandom_range(0, 3));
      case (p)
        0: begin
          sx  = '0;
          sy  = '0;
          ss  = SIZE_W'(255);
          spt = '0;
          sct = '0;
        end
        1: begin
          sx  = XY_W'(XY_MAX);
          sy  = XY_W'(XY_MAX);
          ss  = SIZE_W'(1);
          spt = PIX_W'(254);
          sct = '0;
        end
        2: ss = '0;
        6: begin
          ss  = SIZE_W'(255);
          sct = 16'hFFFF;
        end
        default: ;
      endcase
      write_reg(gzbpc_pkg::CFG_ORIGIN_X, with_junk(CFG_W'(sx), XY_W));
      write_reg(gzbpc_pkg::CFG_ORIGIN_Y, with_junk(CFG_W'(sy), XY_W));
      write_reg(gzbpc_pkg::CFG_CELL_SIZE, with_junk(CFG_W'(ss), SIZE_W));
      write_reg(gzbpc_pkg::CFG_PIX_THR, with_junk(CFG_W'(spt), PIX_W));
      write_reg(gzbpc_pkg::CFG_CNT_THR, CFG_W'(sct));
      write_reg(gzbpc_pkg::CFG_COLOR_LABEL, with_junk(CFG_W'(scol), LABEL_W));
      if (p == PHASES - 1) idle_en = 1'b0;
      // Long output hold-off so the block backs up into its input
      if (p == 3) hold_req = 1'b1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        flen = $urandom_range(1, 24);
        for (int k = 0; k < flen; k++) begin
          if (csize == 0 || $urandom_range(0, 7) == 0) begin
            px = XY_W'($urandom_range(0, XY_MAX));
            py = XY_W'($urandom_range(0, XY_MAX));
            pv = PIX_W'($urandom_range(0, 255));
          end else begin
            hx = org_x + GRID * csize - 1;
            hy = org_y + GRID * csize - 1;
            if (hx > XY_MAX) hx = XY_MAX;
            if (hy > XY_MAX) hy = XY_MAX;
            px = XY_W'($urandom_range(org_x, hx));
            py = XY_W'($urandom_range(org_y, hy));
            pv = PIX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(pix_thr, 255));
          end
          send_pixel(px, py, pv, k == flen - 1);
        end
        sent += flen;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
